/* rtl/lcdfb_pkg.sv */
// Shared types, codes and the seven-segment table of the LCD frame builder.
// Depends on nothing; every other file of the block uses it by scoped names.
package lcdfb_pkg;

   // Request item as it arrives on the input channel.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] number;
      logic [11:0] command_word;
   } lcdfb_req_type;

   // Frame item as it leaves on the result channel.
   typedef struct packed {
      logic [12:0] frame_word;
      logic [3:0]  frame_length;
      logic        last_frame;
   } lcdfb_rsp_type;

   // Request opcodes.
   localparam logic [1:0] OP_NUMBER  = 2'd0;
   localparam logic [1:0] OP_BLANK   = 2'd1;
   localparam logic [1:0] OP_COMMAND = 2'd2;
   localparam logic [1:0] OP_OFF     = 2'd3;

   // Kinds of decoded task handed from the front end to the back end.
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_CMD  = 2'd1;
   localparam logic [1:0] KIND_OFF  = 2'd2;

   // Symbol codes beyond the decimal digits.
   localparam logic [3:0] SYM_E     = 4'd10;
   localparam logic [3:0] SYM_R     = 4'd11;
   localparam logic [3:0] SYM_BLANK = 4'd12;

   localparam logic [9:0]  ERR_LIMIT       = 10'd1000;
   localparam logic [2:0]  WRITE_PREFIX    = 3'b101;
   localparam logic [12:0] CMD_DISPLAY_OFF = 13'h0804;
   localparam logic [12:0] CMD_SYS_DIS     = 13'h0800;
   localparam logic [3:0]  LEN_DATA        = 4'd13;
   localparam logic [3:0]  LEN_CMD         = 4'd12;
   localparam logic [5:0]  BASE_RESET      = 6'd9;

   // Frame index of the final frame of each task kind.
   localparam logic [2:0] LAST_DATA = 3'd5;
   localparam logic [2:0] LAST_CMD  = 3'd0;
   localparam logic [2:0] LAST_OFF  = 3'd1;

   // Decoded task: three symbols (units first) or a command word.
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  sym0;
      logic [3:0]  sym1;
      logic [3:0]  sym2;
      logic [11:0] command_word;
   } lcdfb_task_type;

   // Seven-segment pattern of a symbol; unused codes light nothing.
   function automatic logic [7:0] seg_code(input logic [3:0] sym);
      logic [7:0] code;
      case (sym)
         4'd0:    code = 8'h7D;
         4'd1:    code = 8'h60;
         4'd2:    code = 8'h3E;
         4'd3:    code = 8'h7A;
         4'd4:    code = 8'h63;
         4'd5:    code = 8'h5B;
         4'd6:    code = 8'h5F;
         4'd7:    code = 8'h70;
         4'd8:    code = 8'h7F;
         4'd9:    code = 8'h7B;
         SYM_E:   code = 8'h1F;
         SYM_R:   code = 8'h06;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

/* rtl/lcdfb_front.sv */
// Front end of the LCD frame builder: accepts requests and decodes them into tasks.
// Depends on lcdfb_pkg; feeds lcdfb_queue.
module lcdfb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  lcdfb_pkg::lcdfb_req_type req_item,
   output logic                   q_push,
   input  logic                   q_full,
   output lcdfb_pkg::lcdfb_task_type q_task
);

   // Stage one holds the hundreds digit and the remainder below one hundred.
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_op_ff;
   logic       s1_err_ff;
   logic [3:0] s1_hund_ff, s1_hund_in;
   logic [6:0] s1_rem_ff, s1_rem_in;
   logic [11:0] s1_cmd_ff;
   logic       accept;
   logic [9:0] low_bits;
   logic [9:0] hund_val;
   logic [3:0] tens;
   logic [6:0] tens_val;
   logic [3:0] units;

   assign req_full    = s1_valid_ff && q_full;
   assign accept      = req_push && !req_full;
   assign s1_valid_in = accept || (s1_valid_ff && q_full);
   assign low_bits    = req_item.number[9:0];

   // Hundreds digit by parallel threshold compares.
   always_comb begin
      s1_hund_in = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (low_bits >= 10'(100 * i)) begin
            s1_hund_in = 4'(i);
         end
      end
      hund_val  = 10'(s1_hund_in) * 10'd100;
      s1_rem_in = 7'(low_bits - hund_val);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_op_ff   <= req_item.opcode;
         s1_err_ff  <= (req_item.number >= 16'(lcdfb_pkg::ERR_LIMIT));
         s1_hund_ff <= s1_hund_in;
         s1_rem_ff  <= s1_rem_in;
         s1_cmd_ff  <= req_item.command_word;
      end
   end

   // Tens and units from the remainder, then symbol selection.
   always_comb begin
      tens = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (s1_rem_ff >= 7'(10 * i)) begin
            tens = 4'(i);
         end
      end
      tens_val = 7'(tens) * 7'd10;
      units    = 4'(s1_rem_ff - tens_val);

      q_task.kind         = lcdfb_pkg::KIND_DATA;
      q_task.sym0         = lcdfb_pkg::SYM_BLANK;
      q_task.sym1         = lcdfb_pkg::SYM_BLANK;
      q_task.sym2         = lcdfb_pkg::SYM_BLANK;
      q_task.command_word = s1_cmd_ff;
      unique case (s1_op_ff)
         lcdfb_pkg::OP_NUMBER: begin
            if (s1_err_ff) begin
               q_task.sym0 = lcdfb_pkg::SYM_R;
               q_task.sym1 = lcdfb_pkg::SYM_R;
               q_task.sym2 = lcdfb_pkg::SYM_E;
            end else begin
               q_task.sym0 = units;
               if (s1_hund_ff != 4'd0 || tens != 4'd0) begin
                  q_task.sym1 = tens;
               end
               if (s1_hund_ff != 4'd0) begin
                  q_task.sym2 = s1_hund_ff;
               end
            end
         end
         lcdfb_pkg::OP_BLANK:   q_task.kind = lcdfb_pkg::KIND_DATA;
         lcdfb_pkg::OP_COMMAND: q_task.kind = lcdfb_pkg::KIND_CMD;
         lcdfb_pkg::OP_OFF:     q_task.kind = lcdfb_pkg::KIND_OFF;
         default:               q_task.kind = lcdfb_pkg::KIND_DATA;
      endcase
   end

   assign q_push = s1_valid_ff;

endmodule

/* rtl/lcdfb_queue.sv */
// Short task queue between the front and back ends of the LCD frame builder.
// Depends on lcdfb_pkg for the task type.
module lcdfb_queue #(
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  lcdfb_pkg::lcdfb_task_type push_task,
   input  logic                     pop,
   output logic                     empty,
   output lcdfb_pkg::lcdfb_task_type head_task
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lcdfb_pkg::lcdfb_task_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_task = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_task;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue fill count beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue fill count did not grow on push");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue fill count did not shrink on pop");

endmodule

/* rtl/lcdfb_back.sv */
// Back end of the LCD frame builder: frames each task, one per cycle unless stalled.
// Depends on lcdfb_pkg; reads tasks from lcdfb_queue.
module lcdfb_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [5:0]               base_addr,
   input  logic                     q_empty,
   input  lcdfb_pkg::lcdfb_task_type q_task,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output lcdfb_pkg::lcdfb_rsp_type rsp_item
);

   logic       out_valid_ff, out_valid_in;
   lcdfb_pkg::lcdfb_rsp_type out_item_ff, frame;
   logic [2:0] k_ff, k_in;
   logic [2:0] last_idx;
   logic       emit;
   logic       is_last;
   logic [3:0] sym;
   logic [7:0] code;
   logic [3:0] nibble;
   logic [5:0] addr;

   always_comb begin
      unique case (q_task.kind)
         lcdfb_pkg::KIND_DATA: last_idx = lcdfb_pkg::LAST_DATA;
         lcdfb_pkg::KIND_CMD:  last_idx = lcdfb_pkg::LAST_CMD;
         lcdfb_pkg::KIND_OFF:  last_idx = lcdfb_pkg::LAST_OFF;
         default:              last_idx = lcdfb_pkg::LAST_CMD;
      endcase
   end

   assign emit    = !q_empty && (!out_valid_ff || rsp_pop);
   assign is_last = (k_ff == last_idx);
   assign q_pop   = emit && is_last;

   // Two frames per symbol: high nibble on even index, low nibble on odd.
   always_comb begin
      case (k_ff[2:1])
         2'd0:    sym = q_task.sym0;
         2'd1:    sym = q_task.sym1;
         default: sym = q_task.sym2;
      endcase
      code   = lcdfb_pkg::seg_code(sym);
      nibble = k_ff[0] ? code[3:0] : code[7:4];
      addr   = base_addr + {3'b000, k_ff};

      frame.last_frame = is_last;
      unique case (q_task.kind)
         lcdfb_pkg::KIND_DATA: begin
            frame.frame_word   = {lcdfb_pkg::WRITE_PREFIX, addr, nibble};
            frame.frame_length = lcdfb_pkg::LEN_DATA;
         end
         lcdfb_pkg::KIND_CMD: begin
            frame.frame_word   = {1'b0, q_task.command_word};
            frame.frame_length = lcdfb_pkg::LEN_CMD;
         end
         lcdfb_pkg::KIND_OFF: begin
            frame.frame_word   = (k_ff == 3'd0) ? lcdfb_pkg::CMD_DISPLAY_OFF
                                                : lcdfb_pkg::CMD_SYS_DIS;
            frame.frame_length = lcdfb_pkg::LEN_CMD;
         end
         default: begin
            frame.frame_word   = {1'b0, q_task.command_word};
            frame.frame_length = lcdfb_pkg::LEN_CMD;
         end
      endcase
   end

   always_comb begin
      k_in = k_ff;
      if (emit) begin
         k_in = is_last ? 3'd0 : k_ff + 3'd1;
      end
      out_valid_in = emit || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         k_ff         <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         k_ff         <= k_in;
      end
      if (emit) begin
         out_item_ff <= frame;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_item_ff;

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= lcdfb_pkg::LAST_DATA)
      else $error("frame index beyond six frames");

   a_cmd_index: assert property (@(posedge clock) disable iff (reset)
      (emit && q_task.kind != lcdfb_pkg::KIND_DATA) |-> (k_ff <= lcdfb_pkg::LAST_OFF))
      else $error("command task frame index too large");

   a_pop_on_emit: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> emit)
      else $error("task retired without emitting its last frame");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> out_valid_ff)
      else $error("stalled frame dropped");

endmodule

/* rtl/lcd_three_digit_frame_builder_core.sv */
// Top level of the three-digit segment LCD frame builder.
// Depends on lcdfb_pkg, lcdfb_front, lcdfb_queue and lcdfb_back.
//
// The block turns display requests into serial frames for a segment LCD
// driver. Requests arrive on a queue-like channel: an item is taken at a
// clock edge with req_push high and req_full low. Frames leave on a second
// queue-like channel: the oldest frame sits on rsp_item while rsp_empty is
// low and is taken at an edge with rsp_pop high.
// A number request and a blank request each give six 13-bit data frames,
// units first; a command request gives one 12-bit frame; a switch-off
// request gives LCD-off followed by system-disable. The final frame of each
// item carries last_frame.
// The first frame of an item is registered in the digit split of the front
// end, then in the task queue and then in the frame former of the back end.
// The back end sends one frame per cycle unless the receiver stalls, so
// an item holds it for all its frames; that frame former sets the rate.
// A short task queue lets the front end keep taking items while the back end
// works or the receiver stalls; req_full rises only once it is full.
// The address register is written through csr_valid and csr_data and is
// always ready; write it only while the block is idle.
// Reset, synchronous and active high, empties every stage and sets the first
// segment address to 9.
module lcd_three_digit_frame_builder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   output logic                     req_full,
   input  lcdfb_pkg::lcdfb_req_type req_item,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output lcdfb_pkg::lcdfb_rsp_type rsp_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [5:0]               csr_data
);

   // Driver RAM address of the first of the six nibbles.
   logic [5:0] base_ff, base_in;

   lcdfb_pkg::lcdfb_task_type push_task, head_task;
   logic q_push, q_full, q_pop, q_empty;

   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_data : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= lcdfb_pkg::BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   // Front end: takes items, splits the number into digits and picks symbols.
   lcdfb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_task   (push_task)
   );

   // Decoded tasks wait here until the back end is free.
   lcdfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .full      (q_full),
      .push_task (push_task),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_task (head_task)
   );

   // Back end: forms one frame per unstalled cycle into the output register.
   lcdfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .base_addr (base_ff),
      .q_empty   (q_empty),
      .q_task    (head_task),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule
